[design/lir_pkg.sv]
// shared constants for the linear interpolation resampler
package lir_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    // most outputs one input transfer can cause
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

endpackage

[design/linear_interp_resampler.sv]
// sequence: after an input transfer each interpolated output passes the check state (multiply),
//   the sum state and the present state; repeated outputs past a block end go from check to present
// flow: the next input is taken only after the last output of the current one is accepted
//   and the sequencer is back in idle; at most 32 outputs per input transfer
// s_tready and cfg_ready are high only while the sequencer is idle, one item in flight
// reset (aresetn low, synchronous): phase and block state cleared, phase_step back to 1.0
module linear_interp_resampler
    import lir_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    localparam int DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int STEP_W     = FRAC_BITS + 4
) (
    input  logic              aclk,
    input  logic              aresetn,

    // phase_step write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [STEP_W-1:0] cfg_data,   // phase_step, unsigned Q4.FRAC

    // source sample stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,    // in_sample
    input  logic              s_tlast,    // in_last

    // resampled stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,    // out_sample, zero padded
    output logic              m_tlast,    // out_last
    output logic              m_tuser     // out_block_end
);

    localparam int PH_W = FRAC_BITS + 5;
    localparam logic [PH_W-1:0]   PH_ONE    = PH_W'(1) << FRAC_BITS;
    localparam logic [PH_W-1:0]   PH_TWO    = PH_W'(1) << (FRAC_BITS + 1);
    localparam logic [STEP_W-1:0] STEP_MIN  = STEP_W'(1) << (FRAC_BITS - 4);
    localparam logic [STEP_W-1:0] STEP_RST  = STEP_W'(1) << FRAC_BITS;
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_RESULTS);
    localparam logic [CNT_W-1:0]  CNT_LASTN = CNT_W'(MAX_RESULTS - 1);

    // sequencer: idle -> check phase -> (multiply -> sum) or repeat -> present output
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_SUM   = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [PH_W-1:0]        ph_reg, ph_next;
    logic [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic                   have_prev_reg, have_prev_next;
    logic                   mode_b_reg, mode_b_next;   // 0: interpolating, 1: repeating last
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic [SAMPLE_BITS-1:0] cur_reg, cur_next;
    logic                   last_reg, last_next;
    logic [SAMPLE_BITS-1:0] osmp_reg, osmp_next;
    logic                   olast_reg, olast_next;
    logic                   oend_reg, oend_next;

    logic [STEP_W-1:0]      step_eff;
    logic [PH_W-1:0]        ph_add;
    logic                   room;
    logic                   more_a;
    logic                   more_b;
    logic                   mul_en;
    logic [SAMPLE_BITS-1:0] interp_res;

    // steps below 1/16 are raised to 1/16, which bounds the outputs per item
    assign step_eff = (step_reg < STEP_MIN) ? STEP_MIN : step_reg;
    assign ph_add   = ph_reg + PH_W'(step_eff);

    // lookahead: does another output follow the one being loaded
    assign room   = cnt_reg < CNT_LASTN;
    assign more_a = (ph_add < PH_ONE) || (last_reg && (ph_add < PH_TWO));
    assign more_b = last_reg && (ph_add < PH_ONE);

    lir_interp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_interp (
        .aclk   (aclk),
        .mul_en (mul_en),
        .prev   (prev_reg),
        .cur    (cur_reg),
        .frac   (ph_reg[FRAC_BITS-1:0]),
        .result (interp_res)
    );

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        ph_next        = ph_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        mode_b_next    = mode_b_reg;
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        last_next      = last_reg;
        osmp_next      = osmp_reg;
        olast_next     = olast_reg;
        oend_next      = oend_reg;
        mul_en         = 1'b0;

        // configuration is only written while idle
        if (cfg_valid && cfg_ready) begin
            step_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cur_next    = s_tdata[SAMPLE_BITS-1:0];
                    last_next   = s_tlast;
                    // first sample of a block goes straight to the repeat pass
                    mode_b_next = !have_prev_reg;
                    cnt_next    = '0;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!mode_b_reg) begin
                    if ((ph_reg < PH_ONE) && (cnt_reg < CNT_MAX)) begin
                        mul_en     = 1'b1;
                        state_next = ST_SUM;
                    end else begin
                        ph_next = ph_reg - PH_ONE;
                        if (last_reg) begin
                            mode_b_next = 1'b1;
                        end else begin
                            prev_next      = cur_reg;
                            have_prev_next = 1'b1;
                            state_next     = ST_IDLE;
                        end
                    end
                end else begin
                    if (last_reg && (ph_reg < PH_ONE) && (cnt_reg < CNT_MAX)) begin
                        osmp_next  = cur_reg;
                        olast_next = !(more_b && room);
                        oend_next  = !(more_b && room);
                        state_next = ST_OUT;
                    end else begin
                        // item done
                        if (last_reg) begin
                            ph_next        = '0;
                            prev_next      = '0;
                            have_prev_next = 1'b0;
                        end else begin
                            prev_next      = cur_reg;
                            have_prev_next = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SUM: begin
                osmp_next  = interp_res;
                olast_next = !(more_a && room);
                oend_next  = last_reg && !(more_a && room);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    ph_next    = ph_add;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = ST_CHECK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_RST;
            ph_reg        <= '0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            mode_b_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            ph_reg        <= ph_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            mode_b_reg    <= mode_b_next;
        end
    end

    // item and output payload
    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        cur_reg   <= cur_next;
        last_reg  <= last_next;
        osmp_reg  <= osmp_next;
        olast_reg <= olast_next;
        oend_reg  <= oend_next;
    end

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = DATA_W'(osmp_reg);
    assign m_tlast   = olast_reg;
    assign m_tuser   = oend_reg;

endmodule

[design/lir_interp.sv]
// multiply-add unit: prev + round((cur - prev) * frac)
module lir_interp
    import lir_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   mul_en,
    input  logic [SAMPLE_BITS-1:0] prev,
    input  logic [SAMPLE_BITS-1:0] cur,
    input  logic [FRAC_BITS-1:0]   frac,
    output logic [SAMPLE_BITS-1:0] result
);

    localparam int PW = SAMPLE_BITS + FRAC_BITS + 2;
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);

    logic signed [SAMPLE_BITS:0] diff;
    logic signed [FRAC_BITS:0]   frac_s;
    logic signed [PW-1:0]        prod;
    logic signed [PW-1:0]        prod_reg;
    logic signed [PW-1:0]        shifted;

    assign diff   = $signed({cur[SAMPLE_BITS-1], cur}) - $signed({prev[SAMPLE_BITS-1], prev});
    assign frac_s = $signed({1'b0, frac});
    assign prod   = diff * frac_s + HALF;

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= prod;
        end
    end

    // floor by the fraction width, result always lies between prev and cur
    assign shifted = prod_reg >>> FRAC_BITS;
    assign result  = prev + shifted[SAMPLE_BITS-1:0];

endmodule

[design/lir_checker.sv]
// port-level checks for the resampler, bound to the top level
module lir_checker #(
    parameter int DATA_W = 16
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic              m_tlast,
    input logic              m_tuser
);

    // one item in flight: no input taken while a result is shown
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input ready while output valid");

    // block end only on the final output of an item
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("block end without last");

    // input transfer starts work, ready drops
    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready held after input transfer");

    // each output needs a fresh phase check, no back-to-back outputs
    a_gap_after_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> !m_tvalid)
        else $error("output valid right after transfer");

    // stalled output holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled output changed");

endmodule

bind linear_interp_resampler lir_checker #(
    .DATA_W (DATA_W)
) u_lir_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
